>>> rtl/tga_pkg.sv
package tga_pkg;

  localparam int DIM_W         = 13;
  localparam int ADDR_W        = 24;
  localparam int ARGB_W        = 32;
  localparam int RUN_W         = 8;
  localparam int BYTE_W        = 8;
  localparam int COLOUR_W      = 24;
  localparam int MAX_DIMENSION = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_ORIGIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE      = 3'd4;

  localparam int PACKET_REPEAT_BIT = 7;
  localparam logic [BYTE_W-1:0] OPAQUE_ALPHA = 8'hFF;

  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_BLUE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_GREEN = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RED   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_ALPHA = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             alpha_present;
    logic             top_origin;
    logic             rle_mode;
  } cfg_t;

  // One decoded colour on its way from the byte parser to the address stage.
  typedef struct packed {
    logic [ARGB_W-1:0] argb;
    logic [RUN_W-1:0]  run;
    logic              packet_done;
  } pix_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      res = DIM_W'(MAX_DIMENSION);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> rtl/tga_if.sv
interface tga_byte_if;
  import tga_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface tga_run_if;
  import tga_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] start_address;
  logic [ARGB_W-1:0] pixel_argb;
  logic [RUN_W-1:0]  run_length;
  logic              last_of_image;
  modport source (output valid, output start_address, output pixel_argb,
                  output run_length, output last_of_image, input ready);
  modport sink (input valid, input start_address, input pixel_argb,
                input run_length, input last_of_image, output ready);
endinterface

interface tga_cfg_if;
  import tga_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/tga_front.sv
module tga_front (
  input  logic              clk,
  input  logic              rst_n,
  input  tga_pkg::cfg_t     cfg,
  tga_byte_if.sink          in_chan,
  input  logic              q_full,
  output logic              push,
  output tga_pkg::pix_evt_t evt
);
  import tga_pkg::*;

  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                lit_r, lit_nxt;
  logic [RUN_W-1:0]    left_r, left_nxt;
  logic [COLOUR_W-1:0] colour_r, colour_nxt;
  logic                take;
  logic                is_hdr;
  logic                done;
  logic [BYTE_W-1:0]   b;
  logic [BYTE_W-1:0]   alpha;

  assign in_chan.ready = !q_full;
  assign take          = in_chan.valid && in_chan.ready;
  assign b             = in_chan.stream_byte;
  assign is_hdr        = cfg.rle_mode && (phase_r == PH_BLUE) && (left_r == '0);

  always_comb begin
    phase_nxt       = phase_r;
    lit_nxt         = lit_r;
    left_nxt        = left_r;
    colour_nxt      = colour_r;
    done            = 1'b0;
    alpha           = OPAQUE_ALPHA;
    evt.run         = {{(RUN_W-1){1'b0}}, 1'b1};
    evt.packet_done = 1'b1;
    if (is_hdr) begin
      left_nxt = {1'b0, b[PACKET_REPEAT_BIT-1:0]} + {{(RUN_W-1){1'b0}}, 1'b1};
      lit_nxt  = !b[PACKET_REPEAT_BIT];
    end else begin
      unique case (phase_r)
        PH_BLUE: begin
          colour_nxt[7:0] = b;
          phase_nxt       = PH_GREEN;
        end
        PH_GREEN: begin
          colour_nxt[15:8] = b;
          phase_nxt        = PH_RED;
        end
        PH_RED: begin
          colour_nxt[23:16] = b;
          if (cfg.alpha_present) begin
            phase_nxt = PH_ALPHA;
          end else begin
            phase_nxt = PH_BLUE;
            done      = 1'b1;
          end
        end
        PH_ALPHA: begin
          alpha     = b;
          phase_nxt = PH_BLUE;
          done      = 1'b1;
        end
        default: begin
          phase_nxt = PH_BLUE;
        end
      endcase
      // Packet bookkeeping is skipped in plain mode so a packet can resume later.
      if (done && cfg.rle_mode) begin
        if (lit_r) begin
          left_nxt        = left_r - {{(RUN_W-1){1'b0}}, 1'b1};
          evt.packet_done = (left_nxt == '0);
        end else begin
          evt.run  = left_r;
          left_nxt = '0;
        end
      end
    end
    evt.argb = {alpha, colour_nxt};
  end

  assign push = take && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BLUE;
      lit_r    <= 1'b0;
      left_r   <= '0;
      colour_r <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      lit_r    <= lit_nxt;
      left_r   <= left_nxt;
      colour_r <= colour_nxt;
    end
  end

endmodule

>>> rtl/tga_fifo.sv
module tga_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tga_pkg::pix_evt_t   wr_data,
  input  logic                pop,
  output tga_pkg::pix_evt_t   rd_data,
  output tga_pkg::fifo_stat_t stat
);
  import tga_pkg::*;

  pix_evt_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_W:0]   count_r, count_nxt;

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + {{FIFO_PTR_W{1'b0}}, 1'b1};
    end else if (pop && !push) begin
      count_nxt = count_r - {{FIFO_PTR_W{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + {{(FIFO_PTR_W-1){1'b0}}, 1'b1};
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + {{(FIFO_PTR_W-1){1'b0}}, 1'b1};
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/tga_back.sv
module tga_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tga_pkg::cfg_t     cfg,
  input  tga_pkg::pix_evt_t evt,
  input  logic              evt_valid,
  output logic              evt_take,
  tga_run_if.source         out_chan
);
  import tga_pkg::*;

  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;

  logic              s1_valid_r;
  logic [DIM_W:0]    s1_rowterm_r;
  logic [DIM_W-1:0]  s1_col_r;
  logic [ARGB_W-1:0] s1_argb_r;
  logic [RUN_W-1:0]  s1_run_r;
  logic              s1_last_r;

  logic              o_valid_r;
  logic [ADDR_W-1:0] o_addr_r;
  logic [ARGB_W-1:0] o_argb_r;
  logic [RUN_W-1:0]  o_run_r;
  logic              o_last_r;

  logic              s1_ready, s2_ready;
  logic [DIM_W:0]    rowterm, col_sum, row_inc;
  logic              wrap, last;
  logic [ADDR_W-1:0] rowterm_ext, width_ext, row_offset, addr_nxt;

  assign s2_ready = !o_valid_r || out_chan.ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign evt_take = evt_valid && s1_ready;

  // Bottom-up images count rows from the far end; the difference may go negative
  // when the height is shrunk, and the address then wraps.
  always_comb begin
    if (cfg.top_origin) begin
      rowterm = {1'b0, row_r};
    end else begin
      rowterm = {1'b0, cfg.height} - {1'b0, row_r} - {{DIM_W{1'b0}}, 1'b1};
    end
    col_sum = {1'b0, col_r} + {{(DIM_W+1-RUN_W){1'b0}}, evt.run};
    row_inc = {1'b0, row_r} + {{DIM_W{1'b0}}, 1'b1};
    wrap    = evt.packet_done && (col_sum >= {1'b0, cfg.width});
    last    = wrap && (row_inc >= {1'b0, cfg.height});
    col_nxt = wrap ? '0 : col_sum[DIM_W-1:0];
    if (!wrap) begin
      row_nxt = row_r;
    end else if (last) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_inc[DIM_W-1:0];
    end
  end

  assign rowterm_ext = {{(ADDR_W-DIM_W-1){s1_rowterm_r[DIM_W]}}, s1_rowterm_r};
  assign width_ext   = {{(ADDR_W-DIM_W){1'b0}}, cfg.width};
  assign row_offset  = rowterm_ext * width_ext;
  assign addr_nxt    = row_offset + {{(ADDR_W-DIM_W){1'b0}}, s1_col_r};

  always_ff @(posedge clk) begin
    if (evt_take) begin
      s1_rowterm_r <= rowterm;
      s1_col_r     <= col_r;
      s1_argb_r    <= evt.argb;
      s1_run_r     <= evt.run;
      s1_last_r    <= last;
    end
    if (s1_valid_r && s2_ready) begin
      o_addr_r <= addr_nxt;
      o_argb_r <= s1_argb_r;
      o_run_r  <= s1_run_r;
      o_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (evt_take) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (s1_ready) begin
        s1_valid_r <= evt_take;
      end
      if (s2_ready) begin
        o_valid_r <= s1_valid_r;
      end
    end
  end

  assign out_chan.valid         = o_valid_r;
  assign out_chan.start_address = o_addr_r;
  assign out_chan.pixel_argb    = o_argb_r;
  assign out_chan.run_length    = o_run_r;
  assign out_chan.last_of_image = o_last_r;

endmodule

>>> rtl/tga_rle_pixel_decoder_top.sv
// Truecolor pixel-data decoder: one stream byte is taken per clock, sustained, as long
// as the four-entry pixel queue has room. The byte parser turns BGR/BGRA bytes (and, in
// run-length mode, packet headers) into colour records; the address stage pops one record
// a cycle unless the output stalls, tracks row and column and emits a run beat for the
// final byte of a pixel via the queue, row/column register and multiply-add output
// register. Header bytes and the leading colour bytes produce no beat. Configuration
// writes are always accepted and are to be made only while no beat is in flight.
module tga_rle_pixel_decoder_top (
  input logic       clk,
  input logic       rst_n,
  tga_byte_if.sink  in_chan,
  tga_run_if.source out_chan,
  tga_cfg_if.sink   cfg_chan
);
  import tga_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_write;
  logic       push, pop;
  pix_evt_t   evt_in, evt_out;
  fifo_stat_t q_stat;

  assign cfg_chan.ready = 1'b1;
  assign cfg_write      = cfg_chan.valid && cfg_chan.ready;

  // Dimensions are clamped once at write time; every consumer sees legal values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width         <= {{(DIM_W-1){1'b0}}, 1'b1};
      cfg_r.height        <= {{(DIM_W-1){1'b0}}, 1'b1};
      cfg_r.alpha_present <= 1'b0;
      cfg_r.top_origin    <= 1'b0;
      cfg_r.rle_mode      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_chan.index)
        REG_IMAGE_WIDTH:   cfg_r.width         <= clamp_dim(cfg_chan.data);
        REG_IMAGE_HEIGHT:  cfg_r.height        <= clamp_dim(cfg_chan.data);
        REG_ALPHA_PRESENT: cfg_r.alpha_present <= cfg_chan.data[0];
        REG_TOP_ORIGIN:    cfg_r.top_origin    <= cfg_chan.data[0];
        REG_RLE_MODE:      cfg_r.rle_mode      <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  tga_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_chan (in_chan),
    .q_full  (q_stat.full),
    .push    (push),
    .evt     (evt_in)
  );

  tga_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (evt_in),
    .pop     (pop),
    .rd_data (evt_out),
    .stat    (q_stat)
  );

  tga_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .evt       (evt_out),
    .evt_valid (!q_stat.empty),
    .evt_take  (pop),
    .out_chan  (out_chan)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("pixel queue written while full");

  a_stat_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("pixel queue reports full and empty together");

  a_plain_single: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !cfg_r.rle_mode) |-> (evt_in.run == {{(RUN_W-1){1'b0}}, 1'b1}))
    else $error("plain-mode pixel produced a run longer than one");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pixel queue read while empty");

endmodule

>>> tb/tb_tga_rle_pixel_decoder_top.sv
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder_top;
  import tga_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_BYTES  = 80;

  typedef struct packed {
    logic [ADDR_W-1:0] start_address;
    logic [ARGB_W-1:0] pixel_argb;
    logic [RUN_W-1:0]  run_length;
    logic              last_of_image;
  } run_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  tga_byte_if in_if();
  tga_run_if  out_if();
  tga_cfg_if  cfg_if();

  tga_rle_pixel_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the register file.
  logic [DIM_W-1:0] width_reg  = DIM_W'(1);
  logic [DIM_W-1:0] height_reg = DIM_W'(1);
  logic             alpha_en   = 1'b0;
  logic             top_first  = 1'b0;
  logic             rle_en     = 1'b0;

  // Decoder state as the block should hold it.
  logic [DIM_W-1:0]   cur_col    = '0;
  logic [DIM_W-1:0]   cur_row    = '0;
  logic [PHASE_W-1:0] byte_phase = PH_BLUE;
  logic               lit_pkt    = 1'b0;
  logic [RUN_W-1:0]   px_left    = '0;
  logic [COLOUR_W-1:0] colour    = '0;

  run_beat_t pending_runs[$];
  run_beat_t exp_run;

  int error_count   = 0;
  int bytes_sent    = 0;
  int runs_checked  = 0;
  int images_done   = 0;
  int settings_made = 0;
  int stall_cycles  = 0;
  int send_gap_pct  = 0;
  int recv_stall_pct = 0;

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return 32'(v);
  endfunction

  // Advance the expected decoder state by one stream byte.
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    int unsigned w, h, offset, run, ncol, nrow;
    logic [BYTE_W-1:0] alpha;
    logic done, last;
    run_beat_t r;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    alpha = OPAQUE_ALPHA;
    last = 1'b0;
    if (rle_en && byte_phase == PH_BLUE && px_left == 0) begin
      px_left = {1'b0, b[6:0]} + 8'd1;
      lit_pkt = ~b[PACKET_REPEAT_BIT];
      return;
    end
    if (byte_phase == PH_BLUE) begin
      colour[7:0] = b;
      byte_phase = PH_GREEN;
      return;
    end
    if (byte_phase == PH_GREEN) begin
      colour[15:8] = b;
      byte_phase = PH_RED;
      return;
    end
    if (byte_phase == PH_RED) begin
      colour[23:16] = b;
      if (alpha_en) begin
        byte_phase = PH_ALPHA;
        return;
      end
    end else begin
      alpha = b;
    end
    byte_phase = PH_BLUE;

    if (top_first) offset = cur_row * w;
    else offset = (h - cur_row - 1) * w;

    if (!rle_en) begin
      run = 1;
      done = 1'b1;
    end else if (lit_pkt) begin
      run = 1;
      px_left = px_left - 8'd1;
      done = (px_left == 0);
    end else begin
      run = 32'(px_left);
      px_left = '0;
      done = 1'b1;
    end

    r.start_address = ADDR_W'(offset + cur_col);
    r.pixel_argb = {alpha, colour};
    r.run_length = RUN_W'(run);

    ncol = cur_col + run;
    nrow = cur_row;
    if (done && ncol >= w) begin
      ncol = 0;
      nrow = cur_row + 1;
      if (nrow >= h) begin
        nrow = 0;
        byte_phase = PH_BLUE;
        last = 1'b1;
      end
    end
    cur_col = DIM_W'(ncol);
    cur_row = DIM_W'(nrow);
    r.last_of_image = last;
    pending_runs.push_back(r);
  endfunction

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected run beat: start_address %h pixel_argb %h run_length %0d",
               out_if.start_address, out_if.pixel_argb, out_if.run_length);
        error_count++;
      end else begin
        exp_run = pending_runs.pop_front();
        if (out_if.start_address !== exp_run.start_address) begin
          $error("start_address: expected %h, got %h",
                 exp_run.start_address, out_if.start_address);
          error_count++;
        end
        if (out_if.pixel_argb !== exp_run.pixel_argb) begin
          $error("pixel_argb: expected %h, got %h", exp_run.pixel_argb, out_if.pixel_argb);
          error_count++;
        end
        if (out_if.run_length !== exp_run.run_length) begin
          $error("run_length: expected %0d, got %0d", exp_run.run_length, out_if.run_length);
          error_count++;
        end
        if (out_if.last_of_image !== exp_run.last_of_image) begin
          $error("last_of_image: expected %b, got %b",
                 exp_run.last_of_image, out_if.last_of_image);
          error_count++;
        end
        runs_checked++;
        if (exp_run.last_of_image) images_done++;
      end
    end
  end

  // Ends the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.stream_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [BYTE_W-1:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg = data;
      REG_IMAGE_HEIGHT:  height_reg = data;
      REG_ALPHA_PRESENT: alpha_en = data[0];
      REG_TOP_ORIGIN:    top_first = data[0];
      REG_RLE_MODE:      rle_en = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic alpha, input logic top, input logic rle);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_ALPHA_PRESENT, CFG_DATA_W'(alpha));
    write_reg(REG_TOP_ORIGIN, CFG_DATA_W'(top));
    write_reg(REG_RLE_MODE, CFG_DATA_W'(rle));
    cfg_if.valid <= 1'b0;
    settings_made++;
  endtask

  // Hold the input quiet until every expected run is out and the pipe is empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_plain_pixels();
    settle();
    configure(13'd0, 13'd2, 1'b1, 1'b0, 1'b0);
    send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  task automatic test_rle_packets();
    settle();
    configure(13'd8191, 13'd1, 1'b0, 1'b1, 1'b1);
    send_bytes('{8'hFF, 8'h12, 8'h34, 8'h56});
  endtask

  // A literal packet is left half done while plain pixels go by, then resumes.
  task automatic test_mode_switch_mid_packet();
    settle();
    configure(13'd2, 13'd2, 1'b0, 1'b0, 1'b1);
    send_bytes('{8'h01, 8'hA5, 8'h5A, 8'h0F});
    settle();
    configure(13'd2, 13'd2, 1'b0, 1'b0, 1'b0);
    send_bytes('{8'h80, 8'h7F, 8'hF0});
    settle();
    configure(13'd2, 13'd2, 1'b0, 1'b0, 1'b1);
    send_bytes('{8'h3C, 8'hC3, 8'h99});
  endtask

  // The row passes a shrunk height, and the alpha byte is taken after alpha is switched off.
  task automatic test_alpha_and_height_change();
    settle();
    configure(13'd1, 13'd3, 1'b0, 1'b0, 1'b0);
    send_bytes('{8'h11, 8'h22, 8'h33});
    settle();
    configure(13'd1, 13'd1, 1'b1, 1'b0, 1'b0);
    send_bytes('{8'h44, 8'h55, 8'h66});
    settle();
    configure(13'd1, 13'd1, 1'b0, 1'b0, 1'b0);
    send_byte(8'h77);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return DIM_W'($urandom_range(1, 6));
    if (r < 85) return '0;
    if (r < 90) return DIM_W'(MAX_DIMENSION);
    if (r < 93) return DIM_W'(MAX_DIMENSION + 1);
    if (r < 96) return '1;
    return DIM_W'($urandom_range(0, 8191));
  endfunction

  task automatic send_packet();
    int unsigned count, pixels, bpp;
    logic rep_flag;
    rep_flag = 1'($urandom_range(1));
    count = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
    bpp = alpha_en ? 4 : 3;
    pixels = rep_flag ? 1 : count + 1;
    send_byte({rep_flag, 7'(count)});
    repeat (pixels * bpp) send_byte(BYTE_W'($urandom));
  endtask

  task automatic test_random_streams();
    int phase_start;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 79; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 79; end
        default: begin send_gap_pct = 7; recv_stall_pct = 7; end
      endcase
      configure(pick_dim(), pick_dim(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                ($urandom_range(2) != 0));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if (rle_en && $urandom_range(9) != 0) begin
          send_packet();
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
        end
      end
    end
    send_gap_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.stream_byte <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_plain_pixels();
    test_rle_packets();
    test_mode_switch_mid_packet();
    test_alpha_and_height_change();
    test_random_streams();
    settle();

    $display("Decoded %0d stream bytes under %0d register settings into %0d runs,",
             bytes_sent, settings_made, runs_checked);
    $display("closing %0d images across plain, run-length and alpha formats.", images_done);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
